// File: hdl/ttint_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttint_pkg;

  // table geometry
  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // field widths
  localparam int TW  = 63;
  localparam int XW  = 32;
  localparam int QW  = XW + 1;       // quotient and magnitude width
  localparam int PW  = QW + TW;      // product width

  // input modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // classified operations
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_CLAMP  = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [TW-1:0] ts;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] mag;
    logic [TW-1:0] num;
    logic [TW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] q;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/timestamp_track_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Path-point table with linear interpolation on timestamp queries. Items are
// taken by a front register, dropped there when the mode is unused, and passed
// through a two-entry queue to the back end, which owns the point memory
// (1024 entries of 63-bit time and Q16.16 x,y) and the arithmetic. Clear and
// append items give no result, except an append to a full table, which
// reports status 3. A query scans the table through the single memory read
// port, one entry per cycle, stopping at the first entry at or after the query
// time or at the last entry. An interpolated answer adds two passes through
// the shared multiply/divide unit, each a shift-add multiply followed by a
// restoring divide. The result sits in an output register, so the front keeps
// taking items while it waits, until the queue and the front register are full.
module timestamp_track_interpolator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [ttint_pkg::TW-1:0]  time_stamp,
  input  wire logic [ttint_pkg::XW-1:0]  point_x,
  input  wire logic [ttint_pkg::XW-1:0]  point_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ttint_pkg::XW-1:0]       result_x,
  output logic [ttint_pkg::XW-1:0]       result_y,
  output logic [1:0]                     status
);

  // front to queue
  logic            push;
  logic            q_full;
  ttint_pkg::cmd_t push_cmd;

  // queue to back end
  logic            pop;
  logic            q_vld;
  ttint_pkg::cmd_t pop_cmd;

  // back end to shared multiply/divide unit
  ttint_pkg::div_req_t div_req;
  ttint_pkg::div_rsp_t div_rsp;

  ttint_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .time_stamp (time_stamp),
    .point_x    (point_x),
    .point_y    (point_y),
    .push       (push),
    .q_full     (q_full),
    .cmd        (push_cmd)
  );

  ttint_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .vld      (q_vld),
    .pop_cmd  (pop_cmd)
  );

  ttint_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ttint_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_vld     (q_vld),
    .cmd       (pop_cmd),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_x  (result_x),
    .result_y  (result_y),
    .status    (status)
  );

`ifndef SYNTH
  // back end only pops a queued item
  assert property (@(posedge clk) disable iff (rst) pop |-> q_vld)
    else $error("pop from empty queue");
  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("push into full queue");
  // divider is only started when idle
  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  // the done flag of a finished division is not held high
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |=> !div_rsp.done)
    else $error("divider done held longer than one cycle");
`endif

endmodule
`default_nettype wire

// File: hdl/ttint_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ttint_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 mode,
  input  wire logic [ttint_pkg::TW-1:0]   time_stamp,
  input  wire logic [ttint_pkg::XW-1:0]   point_x,
  input  wire logic [ttint_pkg::XW-1:0]   point_y,
  output logic                            push,
  input  wire logic                       q_full,
  output ttint_pkg::cmd_t                 cmd
);

  logic hold_vld;
  logic accept;
  logic keep;

  assign in_stall = hold_vld && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_vld && !q_full;
  // unused mode is taken and dropped here
  assign keep     = (mode == ttint_pkg::MODE_CLEAR) || (mode == ttint_pkg::MODE_APPEND) ||
                    (mode == ttint_pkg::MODE_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (accept && keep) begin
      hold_vld <= 1'b1;
    end else if (push) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      case (mode)
        ttint_pkg::MODE_CLEAR:  cmd.op <= ttint_pkg::OP_CLEAR;
        ttint_pkg::MODE_APPEND: cmd.op <= ttint_pkg::OP_APPEND;
        default:                cmd.op <= ttint_pkg::OP_QUERY;
      endcase
      cmd.ts <= time_stamp;
      cmd.x  <= point_x;
      cmd.y  <= point_y;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ttint_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ttint_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ttint_pkg::cmd_t push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 vld,
  output ttint_pkg::cmd_t      pop_cmd
);

  ttint_pkg::cmd_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign vld     = (fill != 2'd0);
  assign pop_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

// File: hdl/ttint_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ttint_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ttint_pkg::div_req_t req,
  output ttint_pkg::div_rsp_t      rsp
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;

  logic [1:0]                  state;
  logic [5:0]                  cnt;
  logic                        done;
  logic [ttint_pkg::QW-1:0]    mag;
  logic [ttint_pkg::TW-1:0]    num;
  logic [ttint_pkg::TW-1:0]    den;
  logic [ttint_pkg::PW-1:0]    acc;
  logic [ttint_pkg::PW-1:0]    acc_next;
  logic [ttint_pkg::TW-1:0]    rem;
  logic [ttint_pkg::QW-1:0]    low;
  logic [ttint_pkg::QW-1:0]    q;
  logic [ttint_pkg::TW:0]      r2;
  logic [ttint_pkg::TW:0]      diff;
  logic                        ge;

  // shift-add product, msb of the magnitude first
  assign acc_next = {acc[ttint_pkg::PW-2:0], 1'b0} +
                    (mag[ttint_pkg::QW-1] ? {{ttint_pkg::QW{1'b0}}, num} : '0);
  // restoring step; quotient fits in QW bits since num never exceeds den
  assign r2   = {rem, low[ttint_pkg::QW-1]};
  assign diff = r2 - {1'b0, den};
  assign ge   = (r2 >= {1'b0, den});

  assign rsp.busy = (state != D_IDLE);
  assign rsp.done = done;
  assign rsp.q    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            state <= D_MUL;
            cnt   <= '0;
          end
        end
        D_MUL: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(ttint_pkg::QW - 1)) begin
            state <= D_DIV;
            cnt   <= '0;
          end
        end
        D_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(ttint_pkg::QW - 1)) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        mag <= req.mag;
        num <= req.num;
        den <= req.den;
        acc <= '0;
      end
      D_MUL: begin
        acc <= acc_next;
        mag <= {mag[ttint_pkg::QW-2:0], 1'b0};
        if (cnt == 6'(ttint_pkg::QW - 1)) begin
          rem <= acc_next[ttint_pkg::PW-1:ttint_pkg::QW];
          low <= acc_next[ttint_pkg::QW-1:0];
        end
      end
      D_DIV: begin
        rem <= ge ? diff[ttint_pkg::TW-1:0] : r2[ttint_pkg::TW-1:0];
        low <= {low[ttint_pkg::QW-2:0], 1'b0};
        q   <= {q[ttint_pkg::QW-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/ttint_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ttint_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     q_vld,
  input  wire ttint_pkg::cmd_t          cmd,
  output logic                          pop,
  output ttint_pkg::div_req_t           div_req,
  input  wire ttint_pkg::div_rsp_t      div_rsp,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ttint_pkg::XW-1:0]      result_x,
  output logic [ttint_pkg::XW-1:0]      result_y,
  output logic [1:0]                    status
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SCAN = 3'd1;
  localparam logic [2:0] B_DIVX = 3'd2;
  localparam logic [2:0] B_DIVY = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  localparam int TW = ttint_pkg::TW;
  localparam int XW = ttint_pkg::XW;
  localparam int QW = ttint_pkg::QW;
  localparam int CW = ttint_pkg::CW;
  localparam int AW = ttint_pkg::AW;

  logic [TW-1:0] t_mem [ttint_pkg::DEPTH];
  logic [XW-1:0] x_mem [ttint_pkg::DEPTH];
  logic [XW-1:0] y_mem [ttint_pkg::DEPTH];

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] chk_idx;
  logic          chk_vld;
  logic          div_go;
  logic          wr_en;
  logic          rd_en;
  logic          room;

  logic [TW-1:0] rd_t;
  logic [XW-1:0] rd_x;
  logic [XW-1:0] rd_y;
  logic [TW-1:0] qts;
  logic [TW-1:0] prev_t;
  logic [XW-1:0] prev_x;
  logic [XW-1:0] prev_y;
  logic [XW-1:0] x1;
  logic [XW-1:0] y1;
  logic [XW-1:0] x2;
  logic [XW-1:0] y2;
  logic [TW-1:0] num;
  logic [TW-1:0] den;
  logic [XW-1:0] res_x;
  logic [XW-1:0] res_y;
  logic [1:0]    res_st;

  logic [XW-1:0] la;
  logic [XW-1:0] lb;
  logic [QW-1:0] delta;
  logic [QW-1:0] mag;
  logic [QW-1:0] lerp;

  assign room  = (count < CW'(ttint_pkg::DEPTH));
  assign pop   = (state == B_IDLE) && q_vld;
  assign wr_en = pop && (cmd.op == ttint_pkg::OP_APPEND) && room;
  assign rd_en = (state == B_SCAN) && (scan_idx < count);

  // shared lerp arithmetic, x first then y
  assign la    = (state == B_DIVY) ? y1 : x1;
  assign lb    = (state == B_DIVY) ? y2 : x2;
  assign delta = {lb[XW-1], lb} - {la[XW-1], la};
  assign mag   = delta[QW-1] ? (QW'(0) - delta) : delta;
  assign lerp  = delta[QW-1] ? ({la[XW-1], la} - div_rsp.q) : ({la[XW-1], la} + div_rsp.q);

  assign div_req.start = div_go;
  assign div_req.mag   = mag;
  assign div_req.num   = num;
  assign div_req.den   = den;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      t_mem[count[AW-1:0]] <= cmd.ts;
      x_mem[count[AW-1:0]] <= cmd.x;
      y_mem[count[AW-1:0]] <= cmd.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_t <= t_mem[scan_idx[AW-1:0]];
      rd_x <= x_mem[scan_idx[AW-1:0]];
      rd_y <= y_mem[scan_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      chk_vld   <= 1'b0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            case (cmd.op)
              ttint_pkg::OP_CLEAR: count <= '0;
              ttint_pkg::OP_APPEND: begin
                if (room) begin
                  count <= count + CW'(1);
                end else begin
                  res_x  <= '0;
                  res_y  <= '0;
                  res_st <= ttint_pkg::ST_FULL;
                  state  <= B_EMIT;
                end
              end
              ttint_pkg::OP_QUERY: begin
                qts <= cmd.ts;
                if (count == '0) begin
                  res_x  <= '0;
                  res_y  <= '0;
                  res_st <= ttint_pkg::ST_EMPTY;
                  state  <= B_EMIT;
                end else begin
                  scan_idx <= '0;
                  chk_vld  <= 1'b0;
                  state    <= B_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        B_SCAN: begin
          if (rd_en) scan_idx <= scan_idx + CW'(1);
          chk_vld <= rd_en;
          chk_idx <= scan_idx;
          if (chk_vld) begin
            if (rd_t >= qts) begin
              if (chk_idx == '0) begin
                // at or before the first point
                res_x  <= rd_x;
                res_y  <= rd_y;
                res_st <= ttint_pkg::ST_CLAMP;
                state  <= B_EMIT;
              end else begin
                x1     <= prev_x;
                y1     <= prev_y;
                x2     <= rd_x;
                y2     <= rd_y;
                num    <= qts - prev_t;
                den    <= rd_t - prev_t;
                div_go <= 1'b1;
                state  <= B_DIVX;
              end
            end else begin
              prev_t <= rd_t;
              prev_x <= rd_x;
              prev_y <= rd_y;
              if (chk_idx == count - CW'(1)) begin
                // past the last point
                res_x  <= rd_x;
                res_y  <= rd_y;
                res_st <= ttint_pkg::ST_CLAMP;
                state  <= B_EMIT;
              end
            end
          end
        end
        B_DIVX: begin
          if (div_rsp.done) begin
            res_x  <= lerp[XW-1:0];
            div_go <= 1'b1;
            state  <= B_DIVY;
          end
        end
        B_DIVY: begin
          if (div_rsp.done) begin
            res_y  <= lerp[XW-1:0];
            res_st <= ttint_pkg::ST_INTERP;
            state  <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            result_x  <= res_x;
            result_y  <= res_y;
            status    <= res_st;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int TBL_DEPTH = ttint_pkg::DEPTH;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = ttint_pkg::MODE_CLEAR;
  logic [62:0] time_stamp = '0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] result_x;
  logic [31:0] result_y;
  logic [1:0] status;

  timestamp_track_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .time_stamp(time_stamp), .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_x(result_x), .result_y(result_y), .status(status)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  st;
  } answer_t;

  // predictor copy of the point table
  logic [62:0] pt_time [TBL_DEPTH];
  logic signed [31:0] pt_x [TBL_DEPTH];
  logic signed [31:0] pt_y [TBL_DEPTH];
  int n_points;

  answer_t pending_answers[$];
  int mismatches = 0;
  int answers_seen = 0;
  int queries_sent = 0;
  int items_sent = 0;
  longint cycle_count = 0;
  bit hold_output = 0;
  bit hold_done = 0;

  // interpolate one coordinate: a + trunc((b-a)*num/den)
  function automatic logic [31:0] lerp_coord(logic signed [31:0] a, logic signed [31:0] b,
                                             logic [62:0] num, logic [62:0] den);
    logic signed [33:0] diff;
    logic [32:0] mag;
    logic [127:0] prod;
    logic [127:0] quo;
    logic signed [63:0] res;
    diff = {{2{b[31]}}, b} - {{2{a[31]}}, a};
    mag = diff < 0 ? 33'(-diff) : 33'(diff);
    prod = 128'(mag) * 128'(num);
    quo = prod / 128'(den);
    if (diff < 0) res = 64'(a) - 64'(quo);
    else res = 64'(a) + 64'(quo);
    return res[31:0];
  endfunction

  // apply one item to the predictor table, queue an answer when one is due
  task automatic predict_item(logic [1:0] m, logic [62:0] ts, logic [31:0] px,
                              logic [31:0] py);
    answer_t ans;
    int idx;
    bit hit;
    ans = '0;
    idx = 0;
    hit = 0;
    if (m == ttint_pkg::MODE_CLEAR) begin
      n_points = 0;
      return;
    end
    if (m == ttint_pkg::MODE_APPEND) begin
      if (n_points < TBL_DEPTH) begin
        pt_time[n_points] = ts;
        pt_x[n_points] = px;
        pt_y[n_points] = py;
        n_points++;
        return;
      end
      ans.st = ttint_pkg::ST_FULL;
    end else if (m == ttint_pkg::MODE_QUERY) begin
      queries_sent++;
      if (n_points == 0) begin
        ans.st = ttint_pkg::ST_EMPTY;
      end else begin
        for (int i = 0; i < n_points; i++) begin
          if (pt_time[i] >= ts) begin
            idx = i;
            hit = 1;
            break;
          end
        end
        if (hit && idx == 0) begin
          ans.x = pt_x[0];
          ans.y = pt_y[0];
          ans.st = ttint_pkg::ST_CLAMP;
        end else if (!hit) begin
          ans.x = pt_x[n_points-1];
          ans.y = pt_y[n_points-1];
          ans.st = ttint_pkg::ST_CLAMP;
        end else begin
          ans.x = lerp_coord(pt_x[idx-1], pt_x[idx], ts - pt_time[idx-1],
                             pt_time[idx] - pt_time[idx-1]);
          ans.y = lerp_coord(pt_y[idx-1], pt_y[idx], ts - pt_time[idx-1],
                             pt_time[idx] - pt_time[idx-1]);
          ans.st = ttint_pkg::ST_INTERP;
        end
      end
    end else begin
      return;
    end
    pending_answers.push_back(ans);
  endtask

  // offer one item after a random gap, hold it until accepted
  task automatic send_item(logic [1:0] m, logic [62:0] ts, logic [31:0] px,
                           logic [31:0] py);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    time_stamp <= ts;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(m, ts, px, py);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // clear/append items carry no answer but may still be in flight
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [62:0] rand_ts();
    return 63'({$urandom(), $urandom()} >> 1);
  endfunction

  // wide random coordinate, small one now and then
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 32'($signed($urandom_range(0, 200)) - 100);
    return $urandom();
  endfunction

  // checker: compare every accepted answer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer x=%h y=%h status=%0d", result_x, result_y, status);
      end else begin
        answer_t exp_ans;
        exp_ans = pending_answers.pop_front();
        if (result_x !== exp_ans.x || result_y !== exp_ans.y || status !== exp_ans.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: expected x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
                     exp_ans.x, exp_ans.y, exp_ans.st, result_x, result_y, status);
        end
      end
    end
  end

  // receiver stall: random stall bursts with stall-free windows between, or one long hold-off
  initial begin
    int stall_len;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1;
        wait (!hold_output);
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        stall_len = $urandom_range(0, 3);
        if (stall_len != 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // directed: empty table, unused mode, clamps at both ends, interpolation
  task automatic test_directed_edges();
    send_item(ttint_pkg::MODE_QUERY, 63'd5, '0, '0);
    send_item(ttint_pkg::MODE_UNUSED, 63'h7fff_ffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ttint_pkg::MODE_APPEND, 63'd100, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(ttint_pkg::MODE_QUERY, 63'd0, '0, '0);
    send_item(ttint_pkg::MODE_APPEND, 63'h7fff_ffff_ffff_fff0, 32'sh7fff_ffff,
              32'sh8000_0000);
    send_item(ttint_pkg::MODE_QUERY, 63'd100, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'd101, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'h3fff_ffff_ffff_ffff, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'h7fff_ffff_ffff_ffef, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'h7fff_ffff_ffff_ffff, '0, '0);
    // unsorted times: later entry older than earlier one
    send_item(ttint_pkg::MODE_APPEND, 63'd50, 32'h0001_0000, 32'hffff_0000);
    send_item(ttint_pkg::MODE_QUERY, 63'h7fff_ffff_ffff_fff8, '0, '0);
    send_item(ttint_pkg::MODE_CLEAR, '0, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'd1, '0, '0);
    send_item(ttint_pkg::MODE_APPEND, 63'd0, 32'h0000_0003, 32'hffff_fffd);
    send_item(ttint_pkg::MODE_APPEND, 63'd3, 32'h0000_0000, 32'h0000_0000);
    send_item(ttint_pkg::MODE_QUERY, 63'd1, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'd2, '0, '0);
    wait_drained();
  endtask

  // fill the table to capacity, then append past it and scan the full depth
  task automatic test_full_table();
    send_item(ttint_pkg::MODE_CLEAR, '0, '0, '0);
    for (int i = 0; i < TBL_DEPTH; i++)
      send_item(ttint_pkg::MODE_APPEND, 63'(i) * 63'd1000 + 63'd10, rand_coord(),
                rand_coord());
    send_item(ttint_pkg::MODE_APPEND, 63'd5, 32'h1234_5678, 32'h8765_4321);
    send_item(ttint_pkg::MODE_APPEND, 63'h7fff_ffff_ffff_ffff, 32'hffff_ffff, 32'h0);
    send_item(ttint_pkg::MODE_QUERY, 63'd1023 * 63'd1000 + 63'd5, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'd1023 * 63'd1000 + 63'd11, '0, '0);
    send_item(ttint_pkg::MODE_QUERY, 63'd512 * 63'd1000 + 63'd400, '0, '0);
    wait_drained();
  endtask

  // random paths: small sorted tables, now and then with an unsorted append, and queries inside and around them
  task automatic test_random_paths(int n_items);
    logic [62:0] t_now;
    logic [62:0] step;
    int sent;
    int r;
    sent = 0;
    while (sent < n_items) begin
      send_item(ttint_pkg::MODE_CLEAR, '0, '0, '0);
      t_now = ($urandom_range(0, 1) != 0) ? rand_ts() >> 2 : 63'($urandom_range(0, 50));
      for (int k = $urandom_range(0, 12); k > 0; k--) begin
        step = ($urandom_range(0, 2) == 0) ? rand_ts() >> 4 : 63'($urandom_range(1, 1000));
        t_now = t_now + step;
        send_item(ttint_pkg::MODE_APPEND, t_now, rand_coord(), rand_coord());
        sent++;
      end
      for (int k = $urandom_range(1, 8); k > 0; k--) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_item(ttint_pkg::MODE_UNUSED, rand_ts(), $urandom(), $urandom());
        else if (r == 1) send_item(ttint_pkg::MODE_APPEND, rand_ts(), $urandom(), $urandom());
        else if (r == 2) send_item(ttint_pkg::MODE_QUERY, rand_ts(), $urandom(), $urandom());
        else send_item(ttint_pkg::MODE_QUERY, t_now - (rand_ts() % (t_now + 63'd2)), '0, '0);
        sent++;
      end
    end
  endtask

  // receiver holds off long while the sender keeps offering queries
  task automatic test_output_backpressure();
    send_item(ttint_pkg::MODE_CLEAR, '0, '0, '0);
    send_item(ttint_pkg::MODE_APPEND, 63'd10, 32'h0000_0000, 32'h0000_0000);
    send_item(ttint_pkg::MODE_APPEND, 63'd20, 32'h000a_0000, 32'hfff6_0000);
    hold_done = 0;
    hold_output = 1;
    for (int i = 0; i < 12; i++)
      send_item(ttint_pkg::MODE_QUERY, 63'($urandom_range(5, 25)), '0, '0);
    in_valid <= 1'b0;
    wait (hold_done);
    hold_output = 0;
    @(negedge clk);
    wait_drained();
  endtask

  initial begin
    n_points = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_full_table();
    test_random_paths(400);
    wait_drained();
    test_output_backpressure();
    wait_drained();
    $display("covered %0d items, %0d queries, %0d answers checked, incl. full table",
             items_sent, queries_sent, answers_seen);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ttint_pkg.sv
hdl/ttint_front.sv
hdl/ttint_fifo.sv
hdl/ttint_div.sv
hdl/ttint_back.sv
hdl/timestamp_track_interpolator.sv
dv/tb_top.sv
